// File: sv/ljie_pkg.sv
// ----------------------------------------------------------------------------
// ljie_pkg
// Types, register indexes and sequencing codes for the Lennard-Jones
// insertion energy unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ljie_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_DIAMETER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_DEPTH    = 3'd4;

  localparam logic [23:0] PROBE_DIAMETER_RST = 24'd65536;
  localparam logic [31:0] PROBE_DEPTH_RST    = 32'd65536;

  typedef struct packed {
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic signed [31:0] nbr_z;
    logic        [23:0] nbr_size;
    logic        [31:0] nbr_depth;
    logic               is_final;
  } ljie_in_t;

  typedef struct packed {
    logic signed [63:0] energy;
    logic               clipped;
  } ljie_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX,
    ST_AY,
    ST_AZ,
    ST_S2,
    ST_DPROD,
    ST_DIV,
    ST_SQRT,
    ST_R4,
    ST_R6,
    ST_R12,
    ST_TREP,
    ST_TATT,
    ST_EMIT
  } ljie_state_t;

  typedef struct packed {
    logic        load;
    logic        start;
    ljie_state_t op;
    logic        emit;
  } ljie_cmd_t;

  typedef struct packed {
    logic done;
    logic final_item;
    logic out_free;
  } ljie_status_t;

endpackage

`default_nettype wire

// File: sv/ljie_ctrl.sv
// ----------------------------------------------------------------------------
// ljie_ctrl
// Sequencer: steps one neighbor word through the shared units of the
// datapath and hands the energy word out on the last neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ljie_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  ljie_pkg::ljie_status_t status,
  output ljie_pkg::ljie_cmd_t    cmd
);
  import ljie_pkg::*;

  ljie_state_t state;
  ljie_state_t state_next;
  logic        launch;
  logic        launch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid)    state_next = ST_AX;
      ST_AX:    if (status.done) state_next = ST_AY;
      ST_AY:    if (status.done) state_next = ST_AZ;
      ST_AZ:    if (status.done) state_next = ST_S2;
      ST_S2:    if (status.done) state_next = ST_DPROD;
      ST_DPROD: if (status.done) state_next = ST_DIV;
      ST_DIV:   if (status.done) state_next = ST_SQRT;
      ST_SQRT:  if (status.done) state_next = ST_R4;
      ST_R4:    if (status.done) state_next = ST_R6;
      ST_R6:    if (status.done) state_next = ST_R12;
      ST_R12:   if (status.done) state_next = ST_TREP;
      ST_TREP:  if (status.done) state_next = ST_TATT;
      ST_TATT:  if (status.done) state_next = status.final_item ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    launch_next = (state_next != state) && (state_next != ST_IDLE) &&
                  (state_next != ST_EMIT);
    in_stall  = (state != ST_IDLE);
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.start = launch;
    cmd.op    = state;
    cmd.emit  = (state == ST_EMIT) && status.out_free;
  end

endmodule

`default_nettype wire

// File: sv/ljie_dp.sv
// ----------------------------------------------------------------------------
// ljie_dp
// Datapath: probe registers, a 64x64 multiplier built from one 32x32
// product over four passes, a bit-serial divider, a bit-pair square root,
// the saturating sums and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ljie_dp #(
  parameter int COORD_FRAC_BITS = ljie_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [ljie_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire  [ljie_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  ljie_pkg::ljie_in_t                   in_word,
  input  ljie_pkg::ljie_cmd_t                  cmd,
  output ljie_pkg::ljie_status_t               status,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output ljie_pkg::ljie_out_t                  out_word
);
  import ljie_pkg::*;

  localparam int SH = 2 * COORD_FRAC_BITS - 2;
  localparam int DW = 48 + SH;
  localparam int CW = $clog2(DW);

  logic signed [31:0] probe_x, probe_y, probe_z;
  logic        [23:0] probe_diameter;
  logic        [31:0] probe_depth;

  ljie_in_t    item;
  ljie_state_t op_q;
  logic [23:0] sigma;
  logic [63:0] dd, dprod, r2, r4, r6, r12;
  logic [47:0] s2;
  logic [31:0] depth;
  logic [62:0] rep_sum, att_sum;
  logic        clip_seen;

  // multiplier
  logic [63:0]  mul_a, mul_b, pp;
  logic [127:0] acc, pp_sh;
  logic [2:0]   mul_k;
  logic [1:0]   kp;
  logic [31:0]  pa, pb;
  logic         mul_busy, mul_fin;

  // divider
  logic [DW-1:0] dvd;
  logic [63:0]   rem, quo;
  logic [64:0]   rem_sh;
  logic          div_ge, div_over, div_busy, div_fin;
  logic [CW-1:0] div_i;

  // square root
  logic [63:0] sq_v, sq_res, sq_bit, sq_t;
  logic        sq_busy, sq_fin;

  logic signed [32:0] diff_c;
  logic        [32:0] abs_d;
  logic [63:0] opa, opb;
  logic        is_div, is_sqrt;

  logic        r_sat, t_sat;
  logic [63:0] r_val;
  logic [62:0] t_val;
  logic [63:0] rep_add, att_add;
  logic [63:0] diff_e;
  logic        e_hi, e_lo;
  logic signed [63:0] energy_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_x        <= '0;
      probe_y        <= '0;
      probe_z        <= '0;
      probe_diameter <= PROBE_DIAMETER_RST;
      probe_depth    <= PROBE_DEPTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PROBE_X:        probe_x        <= cfg_data;
        REG_PROBE_Y:        probe_y        <= cfg_data;
        REG_PROBE_Z:        probe_z        <= cfg_data;
        REG_PROBE_DIAMETER: probe_diameter <= cfg_data[23:0];
        REG_PROBE_DEPTH:    probe_depth    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_div  = (cmd.op == ST_DIV);
    is_sqrt = (cmd.op == ST_SQRT);
    unique case (cmd.op)
      ST_AY:   diff_c = 33'(item.nbr_y) - 33'(probe_y);
      ST_AZ:   diff_c = 33'(item.nbr_z) - 33'(probe_z);
      default: diff_c = 33'(item.nbr_x) - 33'(probe_x);
    endcase
    abs_d = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
    unique case (cmd.op)
      ST_S2:    begin opa = 64'(sigma);          opb = 64'(sigma);       end
      ST_DPROD: begin opa = 64'(item.nbr_depth); opb = 64'(probe_depth); end
      ST_R4:    begin opa = r2;                  opb = r2;               end
      ST_R6:    begin opa = r4;                  opb = r2;               end
      ST_R12:   begin opa = r6;                  opb = r6;               end
      ST_TREP:  begin opa = 64'(depth);          opb = r12;              end
      ST_TATT:  begin opa = 64'(depth);          opb = r6;               end
      default:  begin opa = 64'(abs_d);          opb = 64'(abs_d);       end
    endcase
  end

  always_comb begin
    pa = mul_k[0] ? mul_a[63:32] : mul_a[31:0];
    pb = mul_k[1] ? mul_b[63:32] : mul_b[31:0];
    kp = 2'(mul_k - 3'd1);
    unique case (kp)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_fin  <= 1'b0;
    end else begin
      mul_fin <= 1'b0;
      if (cmd.start && !is_div && !is_sqrt) begin
        mul_busy <= 1'b1;
        mul_k    <= '0;
        acc      <= '0;
        mul_a    <= opa;
        mul_b    <= opb;
      end else if (mul_busy) begin
        if (mul_k != 3'd4) pp <= pa * pb;
        if (mul_k != 3'd0) acc <= acc + pp_sh;
        mul_k <= mul_k + 3'd1;
        if (mul_k == 3'd4) begin
          mul_busy <= 1'b0;
          mul_fin  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rem_sh = {rem, dvd[DW-1]};
    div_ge = (rem_sh >= {1'b0, dd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
    end else begin
      div_fin <= 1'b0;
      if (cmd.start && is_div) begin
        if (dd == 64'd0) begin
          quo      <= '1;
          div_over <= 1'b1;
          div_fin  <= 1'b1;
        end else begin
          dvd      <= DW'(s2) << SH;
          rem      <= '0;
          quo      <= '0;
          div_over <= 1'b0;
          div_i    <= CW'(DW - 1);
          div_busy <= 1'b1;
        end
      end else if (div_busy) begin
        rem <= div_ge ? 64'(rem_sh - {1'b0, dd}) : rem_sh[63:0];
        quo <= {quo[62:0], div_ge};
        if (div_ge && (32'(div_i) >= 32'd64)) div_over <= 1'b1;
        dvd <= dvd << 1;
        if (div_i == '0) begin
          div_busy <= 1'b0;
          div_fin  <= 1'b1;
        end else begin
          div_i <= div_i - CW'(1);
        end
      end
    end
  end

  assign sq_t = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_fin  <= 1'b0;
    end else begin
      sq_fin <= 1'b0;
      if (cmd.start && is_sqrt) begin
        sq_v    <= dprod;
        sq_res  <= '0;
        sq_bit  <= 64'd1 << 62;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_v >= sq_t) begin
          sq_v   <= sq_v - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit[0]) begin
          sq_busy <= 1'b0;
          sq_fin  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    r_sat   = (acc[127:96] != '0);
    r_val   = r_sat ? '1 : acc[95:32];
    t_sat   = (acc[127:87] != '0);
    t_val   = t_sat ? '1 : acc[86:24];
    rep_add = {1'b0, rep_sum} + {1'b0, t_val};
    att_add = {1'b0, att_sum} + {1'b0, t_val};
    diff_e  = {1'b0, rep_sum} - {1'b0, att_sum};
    e_hi    = !diff_e[63] && (diff_e[62:61] != 2'b00);
    e_lo    = diff_e[63] && (diff_e[62:61] != 2'b11);
    if (e_hi)      energy_v = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (e_lo) energy_v = 64'sh8000_0000_0000_0000;
    else           energy_v = {diff_e[61:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_sum   <= '0;
      att_sum   <= '0;
      clip_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) op_q <= cmd.op;
      if (cmd.load) begin
        item  <= in_word;
        sigma <= 24'((25'(in_word.nbr_size) + 25'(probe_diameter)) >> 1);
        dd    <= '0;
      end
      if (mul_fin) begin
        unique case (op_q)
          ST_S2:    s2    <= acc[47:0];
          ST_DPROD: dprod <= acc[63:0];
          ST_R4:    begin r4  <= r_val; clip_seen <= clip_seen | r_sat; end
          ST_R6:    begin r6  <= r_val; clip_seen <= clip_seen | r_sat; end
          ST_R12:   begin r12 <= r_val; clip_seen <= clip_seen | r_sat; end
          ST_TREP: begin
            rep_sum   <= rep_add[63] ? '1 : rep_add[62:0];
            clip_seen <= clip_seen | t_sat | rep_add[63];
          end
          ST_TATT: begin
            att_sum   <= att_add[63] ? '1 : att_add[62:0];
            clip_seen <= clip_seen | t_sat | att_add[63];
          end
          default:  dd <= dd + acc[65:2];
        endcase
      end
      if (div_fin) begin
        r2        <= div_over ? '1 : quo;
        clip_seen <= clip_seen | div_over;
      end
      if (sq_fin) depth <= sq_res[31:0];
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.emit) begin
        out_word.energy  <= energy_v;
        out_word.clipped <= clip_seen | e_hi | e_lo;
        out_valid        <= 1'b1;
        rep_sum          <= '0;
        att_sum          <= '0;
        clip_seen        <= 1'b0;
      end
    end
  end

  always_comb begin
    status.done       = mul_fin | div_fin | sq_fin;
    status.final_item = item.is_final;
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// File: sv/lennard_jones_insertion_energy_unit.sv
// ----------------------------------------------------------------------------
// lennard_jones_insertion_energy_unit
// Lennard-Jones 12-6 energy of a probe particle against a stream of
// neighbors, with saturating fixed-point sums.
// ----------------------------------------------------------------------------
// One neighbor word is taken at a time and occupies the unit for ten
// passes of the shared 64x64 multiplier, the bit-serial divider at one
// quotient bit per cycle over 2*COORD_FRAC_BITS + 46 bits, and the
// square root at one result bit per cycle over 32 bits. The energy word
// is loaded into the output register after the last neighbor's work, once
// that register is free, and the next neighbor is taken while that word
// waits in the output register.
`default_nettype none

module lennard_jones_insertion_energy_unit #(
  parameter int COORD_FRAC_BITS = ljie_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [ljie_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire  [ljie_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  ljie_pkg::ljie_in_t              in_word,
  output logic                            out_valid,
  input  wire                             out_stall,
  output ljie_pkg::ljie_out_t             out_word
);
  import ljie_pkg::*;

  ljie_cmd_t    cmd;
  ljie_status_t status;

  ljie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ljie_dp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> in_stall)
    else $error("unit started while idle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    status.done |-> in_stall)
    else $error("unit finished while idle");

  a_emit_final: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (status.final_item && status.out_free))
    else $error("energy word issued without a last neighbor");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("energy word lost");

endmodule

`default_nettype wire

// File: dv/lennard_jones_insertion_energy_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_insertion_energy_unit_tb
// Self-checking bench for the Lennard-Jones insertion energy unit. A
// predictor computes the energy word of each evaluation from the probe
// settings and the neighbor words; a monitor compares the unit's energy
// words against it under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lennard_jones_insertion_energy_unit_tb;
  import ljie_pkg::*;

  localparam int FRAC = COORD_FRAC_BITS_DEF;
  localparam int WORK_CYCLES = 2 * FRAC + 161;
  localparam logic [63:0] SUM_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  ljie_in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ljie_out_t out_word;

  lennard_jones_insertion_energy_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // probe settings and running sums of the predictor
  logic signed [31:0] px, py, pz;
  logic [23:0] pdiam;
  logic [31:0] pdepth;
  logic [63:0] rep_sum, att_sum;
  logic clip_acc;

  ljie_in_t neighbor_q[$];
  ljie_out_t energy_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_out = 1'b0;
  bit done = 1'b0;

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int sh, input logic [63:0] cap,
                                            inout logic clip);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p > {64'd0, cap}) begin
      clip = 1'b1;
      return cap;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
                                          inout logic clip);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, SUM_CAP}) begin
      clip = 1'b1;
      return SUM_CAP;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] dist_quarter(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [33:0] d;
    logic [33:0] m;
    logic [67:0] sq;
    d = 34'(a) - 34'(b);
    m = d < 0 ? -d : d;
    sq = {34'd0, m} * {34'd0, m};
    return sq[65:2];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_energy(input ljie_in_t w);
    logic clip;
    logic [24:0] ssum;
    logic [63:0] sigma, s2, dd, r2, r4, r6, r12, dep;
    logic [127:0] num, q;
    logic signed [63:0] diff;
    ljie_out_t e;
    clip = clip_acc;
    ssum = {1'b0, w.nbr_size} + {1'b0, pdiam};
    sigma = {40'd0, ssum[24:1]};
    s2 = sigma * sigma;
    dd = dist_quarter(w.nbr_x, px) + dist_quarter(w.nbr_y, py) + dist_quarter(w.nbr_z, pz);
    if (dd == 0) begin
      clip = 1'b1;
      r2 = '1;
    end else begin
      num = {64'd0, s2} << (2 * FRAC - 2);
      q = num / {64'd0, dd};
      if (q[127:64] != 0) begin
        clip = 1'b1;
        r2 = '1;
      end else begin
        r2 = q[63:0];
      end
    end
    r4 = mul_shift(r2, r2, 32, '1, clip);
    r6 = mul_shift(r4, r2, 32, '1, clip);
    r12 = mul_shift(r6, r6, 32, '1, clip);
    dep = root_floor({32'd0, w.nbr_depth} * {32'd0, pdepth});
    rep_sum = add_sat(rep_sum, mul_shift(dep, r12, 24, SUM_CAP, clip), clip);
    att_sum = add_sat(att_sum, mul_shift(dep, r6, 24, SUM_CAP, clip), clip);
    clip_acc = clip;
    if (w.is_final) begin
      diff = $signed(rep_sum) - $signed(att_sum);
      if (diff > 64'sh1FFF_FFFF_FFFF_FFFF) begin
        e.energy = 64'sh7FFF_FFFF_FFFF_FFFF;
        clip = 1'b1;
      end else if (diff < -64'sh2000_0000_0000_0000) begin
        e.energy = 64'sh8000_0000_0000_0000;
        clip = 1'b1;
      end else begin
        e.energy = diff <<< 2;
      end
      e.clipped = clip;
      energy_q.push_back(e);
      rep_sum = 0;
      att_sum = 0;
      clip_acc = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_energy(in_word);
        void'(neighbor_q.pop_front());
      end
      if (neighbor_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= neighbor_q[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (energy_q.size() == 0) begin
          report_mismatch("energy word with nothing expected");
        end else begin
          if (out_word.energy !== energy_q[0].energy)
            report_mismatch($sformatf("energy %h, expected %h", out_word.energy,
                                      energy_q[0].energy));
          if (out_word.clipped !== energy_q[0].clipped)
            report_mismatch($sformatf("clipped %b, expected %b", out_word.clipped,
                                      energy_q[0].clipped));
          void'(energy_q.pop_front());
        end
      end
      out_stall <= hold_out || ($urandom_range(99) < stall_pct);
    end
  end

  function automatic ljie_in_t rand_neighbor(input bit fin);
    ljie_in_t w;
    int k;
    k = $urandom_range(9);
    if (k < 6) begin
      // neighbor a few angstroms from the probe
      w.nbr_x = px + $signed(32'($urandom_range(0, 20 << FRAC)) - (32'd10 << FRAC));
      w.nbr_y = py + $signed(32'($urandom_range(0, 20 << FRAC)) - (32'd10 << FRAC));
      w.nbr_z = pz + $signed(32'($urandom_range(0, 20 << FRAC)) - (32'd10 << FRAC));
      w.nbr_size = 24'($urandom_range(0, 6 << 16));
      w.nbr_depth = 32'($urandom_range(0, 500 << 16));
    end else begin
      w.nbr_x = $urandom;
      w.nbr_y = $urandom;
      w.nbr_z = $urandom;
      w.nbr_size = 24'($urandom);
      w.nbr_depth = $urandom;
    end
    if (k == 9) begin
      w.nbr_x = px;
      w.nbr_y = py;
      w.nbr_z = pz;
    end
    w.is_final = fin;
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROBE_X: px = val;
      REG_PROBE_Y: py = val;
      REG_PROBE_Z: pz = val;
      REG_PROBE_DIAMETER: pdiam = val[23:0];
      REG_PROBE_DEPTH: pdepth = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (neighbor_q.size() != 0 || in_valid || energy_q.size() != 0) @(posedge clk);
    repeat (WORK_CYCLES + 20) @(posedge clk);
  endtask

  task automatic add_sets(input int n);
    int len;
    repeat (n) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) neighbor_q.push_back(rand_neighbor(i == len - 1));
    end
  endtask

  initial begin
    ljie_in_t w;
    px = 0; py = 0; pz = 0;
    pdiam = PROBE_DIAMETER_RST;
    pdepth = PROBE_DEPTH_RST;
    rep_sum = 0; att_sum = 0; clip_acc = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset probe, field extremes, coincidence, accumulation
    w = '0;
    w.nbr_x = 32'sd1 << FRAC; w.nbr_size = 24'h010000; w.nbr_depth = 32'h10000;
    w.is_final = 1'b1; neighbor_q.push_back(w);
    w = '0; w.is_final = 1'b1; neighbor_q.push_back(w);
    w = '0; w.nbr_x = 32'sh7FFF_FFFF; w.nbr_y = 32'sh8000_0000; w.nbr_z = 32'sh7FFF_FFFF;
    w.nbr_size = '1; w.nbr_depth = '1; w.is_final = 1'b1; neighbor_q.push_back(w);
    w = '0; w.nbr_x = 32'sh0000_4000; w.nbr_size = '1; w.nbr_depth = '1;
    w.is_final = 1'b0; neighbor_q.push_back(w);
    w.nbr_depth = 0; neighbor_q.push_back(w);
    w.nbr_x = 32'sh0003_0000; w.nbr_depth = 32'h0064_0000; w.is_final = 1'b1;
    neighbor_q.push_back(w);
    w = '0; w.nbr_x = 32'sh8000_0000; w.nbr_size = 0; w.nbr_depth = 0; w.is_final = 1'b1;
    neighbor_q.push_back(w);
    drain();

    write_reg(REG_PROBE_X, 32'h8000_0000);
    write_reg(REG_PROBE_Y, 32'h7FFF_FFFF);
    write_reg(REG_PROBE_Z, 32'h0000_0000);
    write_reg(REG_PROBE_DIAMETER, 32'h00FF_FFFF);
    write_reg(REG_PROBE_DEPTH, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'hDEAD_BEEF);
    w = '0; w.nbr_x = 32'sh7FFF_FFFF; w.nbr_y = 32'sh8000_0000; w.nbr_depth = '1;
    w.nbr_size = '1; w.is_final = 1'b1; neighbor_q.push_back(w);
    w = '0; w.nbr_x = px; w.nbr_y = py; w.is_final = 1'b1; neighbor_q.push_back(w);
    add_sets(5);
    drain();

    write_reg(REG_PROBE_DIAMETER, 32'h0);
    write_reg(REG_PROBE_DEPTH, 32'h0);
    add_sets(5);
    drain();

    // random phases over several probe settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PROBE_X, $urandom);
      write_reg(REG_PROBE_Y, $urandom);
      write_reg(REG_PROBE_Z, $urandom);
      write_reg(REG_PROBE_DIAMETER, $urandom_range(1 << 16, 5 << 16));
      write_reg(REG_PROBE_DEPTH, $urandom_range(0, 300 << 16));
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 58; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 58; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      add_sets(78);
      if (ph == 2) begin
        // hold off the output long enough for the input to back up
        hold_out = 1'b1;
        repeat (8 * WORK_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      drain();
    end
    done = 1'b1;
  end

  initial begin
    wait (done);
    if (errors == 0) begin
      $display("lennard_jones_insertion_energy_unit test passed");
    end else begin
      $display("lennard_jones_insertion_energy_unit test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("lennard_jones_insertion_energy_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
